@@ rtl/gbts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbts_pkg - shared types and constants of the gap-buffer text store
// Field widths of the stream payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package gbts_pkg;

	// request fields
	localparam int OPCODE_W   = 3;
	localparam int POS_W      = 13;
	localparam int CNT_W      = 13;
	localparam int CHAR_W     = 8;
	localparam int IN_DATA_W  = 40;   // position, count, new_char, zero pad

	// result fields
	localparam int STAT_W     = 2;
	localparam int LEN_W      = 13;
	localparam int OUT_DATA_W = 24;   // read_char, status, text_length, zero pad

	// longest read, and the width of the read index
	localparam int MAX_READ   = 64;
	localparam int RIDX_W     = $clog2(MAX_READ + 1);

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STAT_W-1:0]   status_t;

	localparam opcode_t OP_CLEAR  = 3'd0;
	localparam opcode_t OP_INSERT = 3'd1;
	localparam opcode_t OP_MOVE   = 3'd2;
	localparam opcode_t OP_ERASE  = 3'd3;
	localparam opcode_t OP_READ   = 3'd4;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_POS   = 2'd2;
	localparam status_t STAT_COUNT = 2'd3;

endpackage

@@ rtl/gap_buffer_text_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_unit - gap-buffer text store of fixed capacity
// Sequence: clear, insert, unknown and refused requests pass check and reply;
//   move and erase walk the gap one character per shift step, then reply;
//   read makes one registered memory read and one result load per character.
// Throughput: one request at a time; ready returns with the last result, and
//   a stall of the result stream holds the unit until the result is taken.
// Reset (arst_n low) empties the text at once; the character memory is kept.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit #(
	parameter int CAPACITY = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [12:0] position, [25:13] count, [33:26] new_char, [39:34] zero
	input  logic [gbts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [2:0] opcode
	input  logic [gbts_pkg::OPCODE_W-1:0]    s_axis_tuser,
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] read_char, [9:8] status, [22:10] text_length, [23] zero
	output logic [gbts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast
);
	import gbts_pkg::*;

	// AW addresses the store, PW holds a gap pointer (which may equal the
	// capacity), WW is wide enough to compare any pointer with a position.
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int WW = (PW > POS_W + 1) ? PW : POS_W + 1;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_CHECK   = 6'b000010,
		S_SHIFT   = 6'b000100,
		S_RD_ADDR = 6'b001000,
		S_RD_DATA = 6'b010000,
		S_REPLY   = 6'b100000
	} state_t;

	state_t              state_q;
	opcode_t             op_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHAR_W-1:0]   char_q;
	status_t             stat_q;
	logic [PW-1:0]       gb_q;         // gap begin, also the cursor
	logic [PW-1:0]       gf_q;         // gap finish
	logic [RIDX_W-1:0]   idx_q;        // characters of a read already returned

	// character memory and its registered read data
	logic [CHAR_W-1:0]   mem_q [CAPACITY];
	logic [CHAR_W-1:0]   rdata_q;

	// deferred write of a gap walk: the character held in the registered read data
	logic                wr_pend_s1;
	logic [AW-1:0]       wr_addr_s1;

	// result register
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	status_t             out_stat_q;
	logic                out_last_q;
	logic [LEN_W-1:0]    out_len_q;

	// ------------------------------------------------------------------------
	// Length and request checks
	// ------------------------------------------------------------------------
	logic [PW-1:0] gap_sz;
	logic [PW-1:0] len;
	logic [WW-1:0] len_w, pos_w, cnt_w, gb_w, room;
	logic          full, pos_bad, erase_cnt_bad, read_cnt_bad;

	assign gap_sz        = gf_q - gb_q;
	assign len           = PW'(CAPACITY) - gap_sz;
	assign len_w         = WW'(len);
	assign pos_w         = WW'(pos_q);
	assign cnt_w         = WW'(cnt_q);
	assign gb_w          = WW'(gb_q);
	assign room          = len_w - pos_w;
	assign full          = (len == PW'(CAPACITY));
	assign pos_bad       = (pos_w > len_w);
	assign erase_cnt_bad = (cnt_w > room);
	assign read_cnt_bad  = (cnt_w > WW'(MAX_READ)) || (cnt_w > room);

	// ------------------------------------------------------------------------
	// Shared address unit: one step of a gap walk, or one read address
	// ------------------------------------------------------------------------
	logic          go_left, go_right, walk_done;
	logic [WW-1:0] rd_lpos, rd_phys;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign go_left   = (pos_w < gb_w);
	assign go_right  = (pos_w > gb_w) && (gf_q < PW'(CAPACITY));
	assign walk_done = !go_left && !go_right;

	// logical position to physical slot: skip the gap when past the cursor
	assign rd_lpos = pos_w + WW'(idx_q);
	assign rd_phys = (rd_lpos < gb_w) ? rd_lpos : rd_lpos + WW'(gap_sz);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(gf_q);
		if (state_q == S_SHIFT) begin
			rd_en   = !walk_done;
			rd_addr = go_left ? AW'(gb_q - PW'(1)) : AW'(gf_q);
		end else if (state_q == S_RD_ADDR) begin
			rd_en   = 1'b1;
			rd_addr = AW'(rd_phys);
		end
	end

	// single write port: a deferred walk write, or an insert at the cursor
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [CHAR_W-1:0] wr_data;

	assign wr_en   = wr_pend_s1 ||
	                 ((state_q == S_CHECK) && (op_q == OP_INSERT) && !full);
	assign wr_addr = wr_pend_s1 ? wr_addr_s1 : AW'(gb_q);
	assign wr_data = wr_pend_s1 ? rdata_q : char_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// ------------------------------------------------------------------------
	// Result register: loads when empty or when its result is being taken
	// ------------------------------------------------------------------------
	logic out_free, reply_load, char_load, read_last;

	assign out_free   = !out_valid_q || m_axis_tready;
	assign reply_load = (state_q == S_REPLY) && out_free;
	assign char_load  = (state_q == S_RD_DATA) && out_free;
	assign read_last  = (RIDX_W'(idx_q + RIDX_W'(1)) == cnt_q[RIDX_W-1:0]);

	always_ff @(posedge clk) begin
		if (reply_load || char_load) begin
			out_char_q <= char_load ? rdata_q : '0;
			out_stat_q <= char_load ? STAT_OK : stat_q;
			out_last_q <= char_load ? read_last : 1'b1;
			out_len_q  <= LEN_W'(len);
		end
	end

	// capture the request fields when the request is taken
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= s_axis_tuser;
			pos_q  <= s_axis_tdata[POS_W-1:0];
			cnt_q  <= s_axis_tdata[POS_W +: CNT_W];
			char_q <= s_axis_tdata[POS_W+CNT_W +: CHAR_W];
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stat_q      <= STAT_OK;
			gb_q        <= '0;
			gf_q        <= PW'(CAPACITY);
			idx_q       <= '0;
			wr_pend_s1  <= 1'b0;
			wr_addr_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// hold the result until taken
			if (reply_load || char_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// the deferred write lands this cycle; re-arm only on a walk step
			wr_pend_s1 <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					stat_q  <= STAT_OK;
					idx_q   <= '0;
					state_q <= S_REPLY;
					case (op_q)
						OP_CLEAR: begin
							gb_q <= '0;
							gf_q <= PW'(CAPACITY);
						end
						OP_INSERT: begin
							if (full) begin
								stat_q <= STAT_FULL;
							end else begin
								gb_q <= gb_q + PW'(1);
							end
						end
						OP_MOVE: begin
							if (pos_bad) begin
								stat_q <= STAT_POS;
							end else begin
								state_q <= S_SHIFT;
							end
						end
						OP_ERASE: begin
							if (pos_bad) begin
								stat_q <= STAT_POS;
							end else if (erase_cnt_bad) begin
								stat_q <= STAT_COUNT;
							end else begin
								state_q <= S_SHIFT;
							end
						end
						OP_READ: begin
							if (pos_bad) begin
								stat_q <= STAT_POS;
							end else if (read_cnt_bad) begin
								stat_q <= STAT_COUNT;
							end else if (cnt_q != '0) begin
								state_q <= S_RD_ADDR;
							end
						end
						default: begin
							// unknown operation: answer ok, change nothing
						end
					endcase
				end
				S_SHIFT: begin
					if (go_left) begin
						// carry the character below the gap to its top end
						gb_q       <= gb_q - PW'(1);
						gf_q       <= gf_q - PW'(1);
						wr_addr_s1 <= AW'(gf_q - PW'(1));
						wr_pend_s1 <= 1'b1;
					end else if (go_right) begin
						// carry the character above the gap to its bottom end
						gb_q       <= gb_q + PW'(1);
						gf_q       <= gf_q + PW'(1);
						wr_addr_s1 <= AW'(gb_q);
						wr_pend_s1 <= 1'b1;
					end else begin
						// gap in place: an erase widens it past the doomed text
						if (op_q == OP_ERASE) begin
							gf_q <= gf_q + PW'(cnt_q);
						end
						state_q <= S_REPLY;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						idx_q   <= idx_q + RIDX_W'(1);
						state_q <= read_last ? S_IDLE : S_RD_ADDR;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Ports
	// ------------------------------------------------------------------------
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W - STAT_W - LEN_W){1'b0}},
	                        out_len_q, out_stat_q, out_char_q};

endmodule

@@ rtl/gbts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbts_checker - port-level checks of the gap-buffer text store
// Watches the request and result streams and flags illegal behaviour.
// ----------------------------------------------------------------------------
module gbts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [gbts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast
);
	import gbts_pkg::*;

	status_t           res_stat;
	logic [CHAR_W-1:0] res_char;

	assign res_char = m_axis_tdata[CHAR_W-1:0];
	assign res_stat = m_axis_tdata[CHAR_W +: STAT_W];

	// one request at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while the previous one is in work");

	// a refused request gives exactly one result
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_stat != STAT_OK) |-> m_axis_tlast)
		else $error("error result not marked last");

	// only a successful read carries a character
	a_char_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_char != '0) |-> (res_stat == STAT_OK))
		else $error("character returned with an error status");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind gap_buffer_text_store_unit gbts_checker u_gbts_checker (.*);
